### rtl/core/boot_keyboard_report_to_keys_top_assert.svh
// ----------------------------------------------------------------------------
// boot keyboard report to keys: assertion macros
// concurrent check helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef BOOT_KEYBOARD_REPORT_TO_KEYS_TOP_ASSERT_SVH
`define BOOT_KEYBOARD_REPORT_TO_KEYS_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define BKR_ASSERT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("bkr assertion failed");
// next-cycle implication
`define BKR_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("bkr assertion failed");
`else
`define BKR_ASSERT(lbl, clk_s, rstn_s, ante, cons)
`define BKR_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif

`endif

### rtl/core/bkr_pkg.sv
// ----------------------------------------------------------------------------
// bkr_pkg
// shared types, constants and the usage decoder for the keyboard block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bkr_pkg;

  localparam int KeySlotsDef = 6;
  localparam int QueueDepth  = 2;
  localparam int QLvlW       = $clog2(QueueDepth + 1);
  localparam int QPtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  localparam logic [6:0] MinReportLen = 7'd8;
  localparam logic [7:0] ShiftMask    = 8'h22;

  // usage ranges
  localparam logic [7:0] UsageLetterA = 8'h04;
  localparam logic [7:0] UsageLetterZ = 8'h1D;
  localparam logic [7:0] UsageDigit1  = 8'h1E;
  localparam logic [7:0] UsageDigit0  = 8'h27;
  localparam logic [7:0] UsagePunctLo = 8'h2C;
  localparam logic [7:0] UsagePunctHi = 8'h38;

  // special key usages
  localparam logic [7:0] UsageEnter  = 8'h28;
  localparam logic [7:0] UsageEsc    = 8'h29;
  localparam logic [7:0] UsageBksp   = 8'h2A;
  localparam logic [7:0] UsageTab    = 8'h2B;
  localparam logic [7:0] UsageDelete = 8'h4C;
  localparam logic [7:0] UsageRight  = 8'h4F;
  localparam logic [7:0] UsageLeft   = 8'h50;
  localparam logic [7:0] UsageDown   = 8'h51;
  localparam logic [7:0] UsageUp     = 8'h52;

  // special key codes
  localparam logic [3:0] SpEnter  = 4'd0;
  localparam logic [3:0] SpEsc    = 4'd1;
  localparam logic [3:0] SpBksp   = 4'd2;
  localparam logic [3:0] SpDelete = 4'd3;
  localparam logic [3:0] SpTab    = 4'd4;
  localparam logic [3:0] SpLeft   = 4'd5;
  localparam logic [3:0] SpRight  = 4'd6;
  localparam logic [3:0] SpUp     = 4'd7;
  localparam logic [3:0] SpDown   = 4'd8;

  localparam logic KindChar    = 1'b0;
  localparam logic KindSpecial = 1'b1;
  localparam logic CmdReport   = 1'b0;
  localparam logic CmdAttach   = 1'b1;

  localparam logic [6:0] DigitPlain [10] = '{
    7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30
  };
  localparam logic [6:0] DigitShift [10] = '{
    7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29
  };
  // zero marks an unmapped usage
  localparam logic [6:0] PunctPlain [13] = '{
    7'h20, 7'h2D, 7'h3D, 7'h5B, 7'h5D, 7'h5C, 7'h00, 7'h3B, 7'h27, 7'h60,
    7'h2C, 7'h2E, 7'h2F
  };
  localparam logic [6:0] PunctShift [13] = '{
    7'h20, 7'h5F, 7'h2B, 7'h7B, 7'h7D, 7'h7C, 7'h00, 7'h3A, 7'h22, 7'h7E,
    7'h3C, 7'h3E, 7'h3F
  };

  typedef struct packed {
    logic       command;
    logic [6:0] report_length;
    logic [7:0] modifiers;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
  } in_t;

  typedef struct packed {
    logic       key_kind;
    logic [6:0] char_code;
    logic [3:0] special_key;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    logic       key_kind;
    logic [6:0] char_code;
    logic [3:0] special_key;
  } ev_t;

  localparam int EvBits = $bits(ev_t);

  typedef struct packed {
    logic      hit;
    ev_t       ev;
  } dec_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QLvlW-1:0] level;
  } q_stat_t;

  function automatic dec_t key_decode(input logic [7:0] u, input logic shift);
    dec_t       d;
    logic [3:0] di;
    logic [3:0] pi;
    logic [6:0] pc;
    d  = '0;
    di = 4'(u - UsageDigit1);
    pi = 4'(u - UsagePunctLo);
    pc = shift ? PunctShift[pi] : PunctPlain[pi];
    if (u >= UsageLetterA && u <= UsageLetterZ) begin
      d.hit          = 1'b1;
      d.ev.char_code = shift ? 7'(u + 8'h3D) : 7'(u + 8'h5D);
    end else if (u >= UsageDigit1 && u <= UsageDigit0) begin
      d.hit          = 1'b1;
      d.ev.char_code = shift ? DigitShift[di] : DigitPlain[di];
    end else if (u >= UsagePunctLo && u <= UsagePunctHi && pc != 7'h00) begin
      d.hit          = 1'b1;
      d.ev.char_code = pc;
    end else begin
      d.ev.key_kind = KindSpecial;
      d.hit         = 1'b1;
      unique case (u)
        UsageEnter:  d.ev.special_key = SpEnter;
        UsageEsc:    d.ev.special_key = SpEsc;
        UsageBksp:   d.ev.special_key = SpBksp;
        UsageTab:    d.ev.special_key = SpTab;
        UsageDelete: d.ev.special_key = SpDelete;
        UsageRight:  d.ev.special_key = SpRight;
        UsageLeft:   d.ev.special_key = SpLeft;
        UsageDown:   d.ev.special_key = SpDown;
        UsageUp:     d.ev.special_key = SpUp;
        default: begin
          d.hit         = 1'b0;
          d.ev.key_kind = KindChar;
        end
      endcase
    end
    return d;
  endfunction

endpackage

### rtl/core/bkr_front.sv
// ----------------------------------------------------------------------------
// bkr_front
// accepts reports, classifies each slot against the key history
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bkr_front #(
  parameter int KEY_SLOTS = bkr_pkg::KeySlotsDef
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  bkr_pkg::in_t                          in_data,
  input  logic                                  output_enabled,
  input  bkr_pkg::q_stat_t                      q_stat,
  output logic                                  push,
  output logic [KEY_SLOTS*(bkr_pkg::EvBits+1)-1:0] push_data
);
  import bkr_pkg::*;

  logic [7:0]           hist_r   [KEY_SLOTS];
  logic [7:0]           hist_nxt [KEY_SLOTS];
  logic [7:0]           slot     [6];
  logic [KEY_SLOTS-1:0] fire;
  ev_t [KEY_SLOTS-1:0]  evs;
  dec_t                 dec;
  logic                 seen;
  logic                 shift;
  logic                 accept;
  logic                 is_report;

  assign slot[0] = in_data.key_slot_0;
  assign slot[1] = in_data.key_slot_1;
  assign slot[2] = in_data.key_slot_2;
  assign slot[3] = in_data.key_slot_3;
  assign slot[4] = in_data.key_slot_4;
  assign slot[5] = in_data.key_slot_5;

  assign shift     = |(in_data.modifiers & ShiftMask);
  assign in_stall  = q_stat.full;
  assign accept    = in_valid && !q_stat.full;
  assign is_report = (in_data.command == CmdReport) &&
                     (in_data.report_length >= MinReportLen);

  // per-slot classification, slots are independent
  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      dec  = key_decode(slot[i], shift);
      seen = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (hist_r[j] == slot[i]) seen = 1'b1;
      end
      fire[i] = (slot[i] != 8'h00) && !seen && dec.hit;
      evs[i]  = dec.ev;
    end
  end

  assign push      = accept && is_report && output_enabled && (|fire);
  assign push_data = {fire, evs};

  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      hist_nxt[i] = hist_r[i];
      if (accept && in_data.command == CmdAttach) begin
        hist_nxt[i] = 8'h00;
      end else if (accept && is_report) begin
        hist_nxt[i] = slot[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (!rst_n) begin
        hist_r[i] <= 8'h00;
      end else begin
        hist_r[i] <= hist_nxt[i];
      end
    end
  end

endmodule

### rtl/core/bkr_queue.sv
// ----------------------------------------------------------------------------
// bkr_queue
// short register queue of classified reports between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bkr_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output bkr_pkg::q_stat_t q_stat
);
  import bkr_pkg::*;

  logic [WIDTH-1:0] mem_r [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QLvlW-1:0] level_r, level_nxt;

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QueueDepth - 1)) ? '0 : QPtrW'(p + 1'b1);
  endfunction

  assign head_data    = mem_r[rd_ptr_r];
  assign q_stat.full  = (level_r == QLvlW'(QueueDepth));
  assign q_stat.empty = (level_r == '0);
  assign q_stat.level = level_r;

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    level_nxt  = level_r;
    if (push && !pop) level_nxt = QLvlW'(level_r + 1'b1);
    if (pop && !push) level_nxt = QLvlW'(level_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

### rtl/core/bkr_back.sv
// ----------------------------------------------------------------------------
// bkr_back
// walks the pending key events of one report, one event per transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bkr_back #(
  parameter int KEY_SLOTS = bkr_pkg::KeySlotsDef
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic [KEY_SLOTS*(bkr_pkg::EvBits+1)-1:0] head_data,
  input  bkr_pkg::q_stat_t                         q_stat,
  output logic                                     pop,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output bkr_pkg::out_t                            out_data
);
  import bkr_pkg::*;

  logic [KEY_SLOTS-1:0] mask_r, mask_nxt;
  ev_t [KEY_SLOTS-1:0]  evs_r;
  logic [KEY_SLOTS-1:0] head_mask;
  ev_t [KEY_SLOTS-1:0]  head_evs;
  logic [KEY_SLOTS-1:0] low;
  logic [KEY_SLOTS-1:0] rest;
  ev_t                  sel;
  logic                 adv;
  logic                 load;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_data_r;

  assign {head_mask, head_evs} = head_data;

  assign low  = mask_r & KEY_SLOTS'(~mask_r + 1'b1);
  assign rest = mask_r & ~low;
  assign adv  = (|mask_r) && (!out_valid_r || !out_stall);
  assign load = !q_stat.empty && ((mask_r == '0) || (adv && rest == '0));
  assign pop  = load;

  always_comb begin
    sel = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (low[i]) sel = sel | evs_r[i];
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    if (load) begin
      mask_nxt = head_mask;
    end else if (adv) begin
      mask_nxt = rest;
    end
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) evs_r <= head_evs;
    if (adv) begin
      out_data_r.key_kind    <= sel.key_kind;
      out_data_r.char_code   <= sel.char_code;
      out_data_r.special_key <= sel.special_key;
      out_data_r.last_of_run <= (rest == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/boot_keyboard_report_to_keys_top.sv
// ----------------------------------------------------------------------------
// boot_keyboard_report_to_keys_top
// boot keyboard reports in, US-layout key events out
// ----------------------------------------------------------------------------
// path: a report's events are written to the queue, loaded into the back event
//   mask and then registered at the output before the first event is valid
// throughput: one key event per cycle from the back sequencer while out_stall
//   is low, up to KEY_SLOTS per report; the front takes a report each cycle
//   while the 2-entry queue has room
// reset: synchronous active-low rst_n clears key history, queue, output
//   enable and valid flags; no clearing pass
`timescale 1ns / 1ps
`include "boot_keyboard_report_to_keys_top_assert.svh"

module boot_keyboard_report_to_keys_top #(
  parameter int KEY_SLOTS = bkr_pkg::KeySlotsDef
) (
  input  logic          clk,
  input  logic          rst_n,
  // report channel
  input  logic          in_valid,
  output logic          in_stall,
  input  bkr_pkg::in_t  in_data,
  // key event channel
  output logic          out_valid,
  input  logic          out_stall,
  output bkr_pkg::out_t out_data,
  // output enable register write
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data
);
  import bkr_pkg::*;

  localparam int JobW = KEY_SLOTS * (EvBits + 1);

  logic            output_enabled_r, output_enabled_nxt;
  logic            push;
  logic [JobW-1:0] push_data;
  logic            pop;
  logic [JobW-1:0] head_data;
  q_stat_t         q_stat;

  // config write always completes in one transfer
  assign cfg_ready          = 1'b1;
  assign output_enabled_nxt = (cfg_valid && cfg_ready) ? cfg_data : output_enabled_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      output_enabled_r <= 1'b0;
    end else begin
      output_enabled_r <= output_enabled_nxt;
    end
  end

  // front: takes reports, compares slots with the previous report, updates
  // history right away so back-to-back reports see the right history
  bkr_front #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .output_enabled (output_enabled_r),
    .q_stat         (q_stat),
    .push           (push),
    .push_data      (push_data)
  );

  // only reports with at least one event enter the queue
  bkr_queue #(
    .WIDTH (JobW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .q_stat    (q_stat)
  );

  // back: emits pending events in slot order, flags the last of each report
  bkr_back #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_data (head_data),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // special keys carry no character, characters carry a zero special code
  `BKR_ASSERT(a_special_no_char, clk, rst_n, out_valid && out_data.key_kind == KindSpecial, out_data.char_code == 7'h00)
  `BKR_ASSERT(a_char_no_special, clk, rst_n, out_valid && out_data.key_kind == KindChar, out_data.special_key == SpEnter)
  // nothing is queued while output is disabled
  `BKR_ASSERT(a_no_push_disabled, clk, rst_n, !output_enabled_r, !push)
  // queue level tracks a lone push
  `BKR_ASSERT_NEXT(a_level_up, clk, rst_n, push && !pop, q_stat.level == QLvlW'($past(q_stat.level) + 1'b1))

endmodule
